// ===== design/imas_pkg.sv =====
// shared types and constants for the interval min/max/average statistics core
// no dependencies; imported by every module of the core
package imas_pkg;

  // low bits of the sample that take part in the statistics
  localparam int SAMPLE_BITS = 32;

  localparam int DATA_W      = 32;
  localparam int SUM_W       = 64;
  localparam int COUNT_W     = 16;
  localparam int INTERVAL_W  = 16;
  localparam int DIVISOR_W   = 16;
  localparam int CFG_INDEX_W = 8;
  localparam int STEP_W      = $clog2(DATA_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int KEEP_BITS = (SAMPLE_BITS < DATA_W) ? SAMPLE_BITS : DATA_W;
  localparam logic [DATA_W-1:0] SAMPLE_MASK = {DATA_W{1'b1}} >> (DATA_W - KEEP_BITS);

  localparam logic [CFG_INDEX_W-1:0] REG_WARMUP_FRAMES   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_REPORT_INTERVAL = CFG_INDEX_W'(1);

  localparam logic [COUNT_W-1:0]    COUNT_MAX        = {COUNT_W{1'b1}};
  localparam logic [INTERVAL_W-1:0] INTERVAL_DEFAULT = INTERVAL_W'(60);

  typedef enum logic {
    OP_SUBMIT = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0]     warmup_frames;
    logic [INTERVAL_W-1:0] report_interval;
  } cfg_t;

  // last member sits in the lowest bits
  typedef struct packed {
    logic [COUNT_W-1:0] samples_in_report;
    logic [DATA_W-1:0]  maximum_time;
    logic [DATA_W-1:0]  minimum_time;
    logic [DATA_W-1:0]  average_time;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MOD,
    BK_DIV,
    BK_OUT
  } back_state_t;

endpackage

// ===== design/imas_front.sv =====
// front end: takes input transactions, decodes the op and trims the sample
// depends on imas_pkg
module imas_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [imas_pkg::DATA_W-1:0] s_axis_tdata,
  input  logic                        s_axis_tuser,
  output logic                        push_valid,
  input  logic                        push_ready,
  output imas_pkg::item_t             push_item
);
  import imas_pkg::*;

  logic  hold_valid;
  item_t hold_item;

  assign s_axis_tready = !hold_valid || push_ready;
  assign push_valid    = hold_valid;
  assign push_item     = hold_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      hold_valid <= 1'b1;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      hold_item.op     <= op_t'(s_axis_tuser);
      hold_item.sample <= s_axis_tdata & SAMPLE_MASK;
    end
  end

endmodule

// ===== design/imas_queue.sv =====
// short fifo of decoded items between front end and back end
// depends on imas_pkg
module imas_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  imas_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output imas_pkg::item_t pop_item
);
  import imas_pkg::*;

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== design/imas_back.sv =====
// back end: accumulators, shared radix-2 divider for the interval test and
// the average, and the output register; depends on imas_pkg
module imas_back (
  input  logic              clk,
  input  logic              rst,
  input  imas_pkg::cfg_t    cfg,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  imas_pkg::item_t   pop_item,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output imas_pkg::result_t m_axis_tdata
);
  import imas_pkg::*;

  back_state_t          state, state_next;
  logic [DATA_W-1:0]    frame_counter, frame_counter_next;
  logic [SUM_W-1:0]     time_sum, time_sum_next;
  logic [DATA_W-1:0]    running_minimum, running_minimum_next;
  logic [DATA_W-1:0]    running_maximum, running_maximum_next;
  logic [COUNT_W-1:0]   sample_counter, sample_counter_next;
  logic [STEP_W-1:0]    step, step_next;
  logic [DATA_W-1:0]    dvd, dvd_next;
  logic [DIVISOR_W-1:0] rem, rem_next;
  logic [DIVISOR_W-1:0] divisor, divisor_next;
  logic                 out_valid, out_valid_next;
  result_t              result, result_next;

  logic [DIVISOR_W:0]   trial;
  logic                 fits;
  logic [DIVISOR_W:0]   rem_step;
  logic [DATA_W-1:0]    dvd_step;
  logic [DATA_W-1:0]    fc_inc;
  logic [SUM_W:0]       sum_wide;
  logic [COUNT_W-1:0]   count_new;

  // one restoring divide step: remainder shifts in the next dividend bit,
  // the quotient bit shifts into the bottom of the dividend register
  assign trial    = {rem, dvd[DATA_W-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign rem_step = fits ? (trial - {1'b0, divisor}) : trial;
  assign dvd_step = {dvd[DATA_W-2:0], fits};

  assign fc_inc   = frame_counter + DATA_W'(1);
  assign sum_wide = {1'b0, time_sum} + (SUM_W + 1)'(pop_item.sample);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = result;

  always_comb begin
    state_next           = state;
    frame_counter_next   = frame_counter;
    time_sum_next        = time_sum;
    running_minimum_next = running_minimum;
    running_maximum_next = running_maximum;
    sample_counter_next  = sample_counter;
    step_next            = step;
    dvd_next             = dvd;
    rem_next             = rem;
    divisor_next         = divisor;
    out_valid_next       = out_valid && !m_axis_tready;
    result_next          = result;
    pop_ready            = 1'b0;
    count_new            = sample_counter;

    unique case (state)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          if (pop_item.op == OP_CLEAR) begin
            frame_counter_next   = '0;
            time_sum_next        = '0;
            running_minimum_next = '1;
            running_maximum_next = '0;
            sample_counter_next  = '0;
          end else begin
            frame_counter_next = fc_inc;
            if (fc_inc > cfg.warmup_frames) begin
              time_sum_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
              if (pop_item.sample < running_minimum) begin
                running_minimum_next = pop_item.sample;
              end
              if (pop_item.sample > running_maximum) begin
                running_maximum_next = pop_item.sample;
              end
              if (sample_counter != COUNT_MAX) begin
                count_new = sample_counter + COUNT_W'(1);
              end
            end
            sample_counter_next = count_new;
            if (cfg.report_interval != '0 && count_new != '0) begin
              dvd_next     = fc_inc;
              rem_next     = '0;
              divisor_next = cfg.report_interval;
              step_next    = '0;
              state_next   = BK_MOD;
            end
          end
        end
      end
      BK_MOD: begin
        dvd_next  = dvd_step;
        rem_next  = rem_step[DIVISOR_W-1:0];
        step_next = step + STEP_W'(1);
        if (step == {STEP_W{1'b1}}) begin
          if (rem_step != '0) begin
            state_next = BK_IDLE;
          end else if (time_sum[SUM_W-1:DATA_W] >= DATA_W'(sample_counter)) begin
            // quotient does not fit in 32 bits
            dvd_next   = '1;
            state_next = BK_OUT;
          end else begin
            // high half is below the count, so it is the starting remainder
            rem_next     = time_sum[DATA_W+DIVISOR_W-1:DATA_W];
            dvd_next     = time_sum[DATA_W-1:0];
            divisor_next = sample_counter;
            state_next   = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        dvd_next  = dvd_step;
        rem_next  = rem_step[DIVISOR_W-1:0];
        step_next = step + STEP_W'(1);
        if (step == {STEP_W{1'b1}}) begin
          state_next = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!out_valid || m_axis_tready) begin
          result_next.average_time      = dvd;
          result_next.minimum_time      = running_minimum;
          result_next.maximum_time      = running_maximum;
          result_next.samples_in_report = sample_counter;
          out_valid_next                = 1'b1;
          time_sum_next                 = '0;
          running_minimum_next          = '1;
          running_maximum_next          = '0;
          sample_counter_next           = '0;
          state_next                    = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= BK_IDLE;
      out_valid       <= 1'b0;
      frame_counter   <= '0;
      time_sum        <= '0;
      running_minimum <= '1;
      running_maximum <= '0;
      sample_counter  <= '0;
    end else begin
      state           <= state_next;
      out_valid       <= out_valid_next;
      frame_counter   <= frame_counter_next;
      time_sum        <= time_sum_next;
      running_minimum <= running_minimum_next;
      running_maximum <= running_maximum_next;
      sample_counter  <= sample_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    step    <= step_next;
    dvd     <= dvd_next;
    rem     <= rem_next;
    divisor <= divisor_next;
    result  <= result_next;
  end

endmodule

// ===== design/interval_min_max_average_stats_core.sv =====
// top level of the interval min/max/average statistics core
// depends on imas_pkg, imas_front, imas_queue and imas_back
//
// Frame-time statistics. Each input transaction is either a frame sample
// (tuser low, tdata = Q16.16 ms) or a clear (tuser high). Samples past the
// warmup count are folded into a saturating sum, minimum, maximum and a
// count that stops at 65535; every report_interval frames, if any sample is
// held, one report transaction carries the truncated average (saturated to
// 32 bits), minimum, maximum and count, and the accumulators restart.
// Timing: a clear, or a sample when reporting is off or no sample is held,
// is handled in the back end's idle state. Otherwise the frame-count
// remainder runs on a shared radix-2 divider, 32 steps; on a report frame
// the same divider produces the average in 32 more steps, then the output
// register is loaded when free. The input register and a two-entry queue
// take transactions until full while the back end works or a report waits.
module interval_min_max_average_stats_core (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [imas_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [imas_pkg::DATA_W-1:0]      cfg_data,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [imas_pkg::DATA_W-1:0]      s_axis_tdata,  // sample_time
  input  logic                             s_axis_tuser,  // op
  // report stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // average_time, minimum_time, maximum_time, samples_in_report
  output logic [$bits(imas_pkg::result_t)-1:0] m_axis_tdata
);
  import imas_pkg::*;

  cfg_t    cfg;
  logic    push_valid;
  logic    push_ready;
  item_t   push_item;
  logic    pop_valid;
  logic    pop_ready;
  item_t   pop_item;
  result_t result;

  // register writes are always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warmup_frames   <= '0;
      cfg.report_interval <= INTERVAL_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      priority if (cfg_index == REG_WARMUP_FRAMES) begin
        cfg.warmup_frames <= cfg_data;
      end else if (cfg_index == REG_REPORT_INTERVAL) begin
        cfg.report_interval <= cfg_data[INTERVAL_W-1:0];
      end else begin
        cfg <= cfg;
      end
    end
  end

  // decode and register incoming transactions
  imas_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  // decouples intake from the multi-cycle back end
  imas_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // accumulators, divider and report register
  imas_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_item      (pop_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (result)
  );

  assign m_axis_tdata = result;

endmodule

// ===== test/tb_interval_min_max_average_stats_core.sv =====
// self-checking testbench for interval_min_max_average_stats_core
// depends on imas_pkg and the core; predicts every report and checks it field by field

module tb_interval_min_max_average_stats_core;
  import imas_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // cycles to let in-flight frames finish when no report is pending
  localparam int SETTLE_CYCLES = 300;

  // register indexes past the end of the map; writes to them must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HIGH = {CFG_INDEX_W{1'b1}};

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_INDEX_W-1:0]       cfg_index = '0;
  logic [DATA_W-1:0]            cfg_data = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [DATA_W-1:0]            s_axis_tdata = '0;  // sample_time
  logic                         s_axis_tuser = 1'b0; // op
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  // average_time, minimum_time, maximum_time, samples_in_report
  logic [$bits(result_t)-1:0]   m_axis_tdata;

  interval_min_max_average_stats_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // shadow of the statistics state
  logic [DATA_W-1:0]     warmup_cfg;
  logic [INTERVAL_W-1:0] interval_cfg;
  logic [DATA_W-1:0]     frame_cnt;
  logic [SUM_W-1:0]      sum_acc;
  logic [DATA_W-1:0]     min_acc;
  logic [DATA_W-1:0]     max_acc;
  logic [COUNT_W-1:0]    count_acc;

  result_t     pending_reports[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned reports_seen = 0;

  // stimulus shaping knobs
  bit src_idle  = 1'b1;
  bit sink_idle = 1'b1;
  int sink_hold = 0;

  function automatic void clear_accumulators();
    sum_acc   = '0;
    min_acc   = '1;
    max_acc   = '0;
    count_acc = '0;
  endfunction

  // returns 1 when the frame closes a report window with samples held
  function automatic bit stats_predict(input op_t op, input logic [DATA_W-1:0] raw,
                                       output result_t rep);
    logic [DATA_W-1:0] s;
    logic [SUM_W-1:0]  quot;
    rep = '0;
    if (op == OP_CLEAR) begin
      frame_cnt = '0;
      clear_accumulators();
      return 1'b0;
    end
    s = raw & SAMPLE_MASK;
    frame_cnt = frame_cnt + DATA_W'(1);
    if (frame_cnt > warmup_cfg) begin
      // sum saturates instead of wrapping
      if (SUM_W'(s) > ~sum_acc) sum_acc = '1;
      else sum_acc = sum_acc + SUM_W'(s);
      if (s < min_acc) min_acc = s;
      if (s > max_acc) max_acc = s;
      if (count_acc != COUNT_MAX) count_acc = count_acc + COUNT_W'(1);
    end
    if (interval_cfg == '0 || (frame_cnt % DATA_W'(interval_cfg)) != '0 || count_acc == '0)
      return 1'b0;
    quot = sum_acc / SUM_W'(count_acc);
    rep.average_time      = (quot > SUM_W'({DATA_W{1'b1}})) ? '1 : quot[DATA_W-1:0];
    rep.minimum_time      = min_acc;
    rep.maximum_time      = max_acc;
    rep.samples_in_report = count_acc;
    clear_accumulators();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("mismatch %s: got %h want %h (report %0d, cycle %0d)",
             what, got, want, reports_seen, cycle_count);
    error_count++;
  endtask

  // cycle counter and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[interval_min_max_average_stats_core] ERROR");
      $finish;
    end
  end

  // report checker: every accepted transaction against the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata);
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected report, average", got.average_time, '0);
      end else begin
        want = pending_reports.pop_front();
        if (got.average_time !== want.average_time)
          report_mismatch("average_time", got.average_time, want.average_time);
        if (got.minimum_time !== want.minimum_time)
          report_mismatch("minimum_time", got.minimum_time, want.minimum_time);
        if (got.maximum_time !== want.maximum_time)
          report_mismatch("maximum_time", got.maximum_time, want.maximum_time);
        if (got.samples_in_report !== want.samples_in_report)
          report_mismatch("samples_in_report", DATA_W'(got.samples_in_report),
                          DATA_W'(want.samples_in_report));
      end
      reports_seen++;
    end
  end

  // report sink: random stall bursts, plus a long hold-off on request
  initial begin : report_sink
    int n;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else if (sink_idle && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 19);
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // one frame transaction, with an optional idle burst in front of it
  task automatic send_frame(input op_t op, input logic [DATA_W-1:0] sample);
    int n;
    result_t rep;
    if (src_idle && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 19);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= sample;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (stats_predict(op, sample, rep)) pending_reports.push_back(rep);
  endtask

  // sender pauses until every expected report is back, then lets silent frames finish
  task automatic wait_reports_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_WARMUP_FRAMES) warmup_cfg = value;
    else if (idx == REG_REPORT_INTERVAL) interval_cfg = value[INTERVAL_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [DATA_W-1:0] warmup, input logic [INTERVAL_W-1:0] interval);
    wait_reports_drained();
    write_reg(REG_WARMUP_FRAMES, warmup);
    write_reg(REG_REPORT_INTERVAL, DATA_W'(interval));
  endtask

  // frame times: full range, typical render times, near the top, corner patterns
  function automatic logic [DATA_W-1:0] random_sample();
    case ($urandom_range(0, 5))
      0, 1: return $urandom();
      2:    return $urandom_range(32'h0008_0000, 32'h0028_0000);
      3:    return $urandom_range(0, 32'h000F_FFFF);
      4:    return 32'hFFFF_FFFF - $urandom_range(0, 32'hFFFF);
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
          default: return ~(DATA_W'(1) << $urandom_range(0, DATA_W - 1));
        endcase
      end
    endcase
  endfunction

  task automatic send_random_frames(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) send_frame(OP_CLEAR, $urandom());
      else send_frame(OP_SUBMIT, random_sample());
    end
  endtask

  // extremes under the reset configuration, then frames up to two default windows
  task automatic test_reset_defaults();
    send_frame(OP_SUBMIT, '0);
    send_frame(OP_SUBMIT, '1);
    send_frame(OP_SUBMIT, 32'h0000_0001);
    send_frame(OP_SUBMIT, 32'h8000_0000);
    send_frame(OP_SUBMIT, 32'h7FFF_FFFF);
    send_frame(OP_SUBMIT, 32'h0010_AAAA);
    for (int i = 0; i < 114; i++) send_frame(OP_SUBMIT, random_sample());
  endtask

  task automatic test_directed_config();
    // every frame reports on its own sample
    configure('0, INTERVAL_W'(1));
    send_frame(OP_SUBMIT, '0);
    send_frame(OP_SUBMIT, '1);
    send_frame(OP_SUBMIT, 32'h0000_0001);
    send_frame(OP_SUBMIT, 32'h8000_0000);
    send_frame(OP_SUBMIT, 32'h7FFF_FFFF);
    // warmup skips two frames, clear restarts the frame count
    configure(DATA_W'(2), INTERVAL_W'(3));
    send_frame(OP_CLEAR, '1);
    send_frame(OP_SUBMIT, 32'h0020_0000);
    send_frame(OP_SUBMIT, 32'h0001_0000);
    send_frame(OP_SUBMIT, 32'h0011_8000);
    send_frame(OP_SUBMIT, 32'h0009_0000);
    send_frame(OP_CLEAR, '0);
    send_frame(OP_SUBMIT, 32'h0000_0002);
    send_frame(OP_SUBMIT, 32'h0000_0003);
    send_frame(OP_SUBMIT, 32'h0012_3456);
    // writes outside the register map leave the settings alone
    wait_reports_drained();
    write_reg(REG_UNUSED_LOW, '0);
    write_reg(REG_UNUSED_HIGH, '1);
    for (int i = 0; i < 3; i++) send_frame(OP_SUBMIT, random_sample());
    // reporting off
    configure('0, '0);
    for (int i = 0; i < 3; i++) send_frame(OP_SUBMIT, random_sample());
    // warmup never ends
    configure('1, INTERVAL_W'(1));
    for (int i = 0; i < 3; i++) send_frame(OP_SUBMIT, random_sample());
    // widest interval
    configure('0, '1);
    for (int i = 0; i < 2; i++) send_frame(OP_SUBMIT, random_sample());
  endtask

  task automatic test_random_sweep();
    int sent;
    logic [INTERVAL_W-1:0] interval;
    logic [DATA_W-1:0]     warmup;
    sent = 0;
    while (sent < 1150) begin
      case ($urandom_range(0, 7))
        0:       interval = INTERVAL_W'(1);
        1, 2:    interval = INTERVAL_W'($urandom_range(2, 8));
        3:       interval = INTERVAL_W'($urandom_range(9, 40));
        4:       interval = '0;
        5:       interval = INTERVAL_W'($urandom_range(1, 65535));
        6:       interval = INTERVAL_DEFAULT;
        default: interval = INTERVAL_W'($urandom_range(1, 20));
      endcase
      case ($urandom_range(0, 7))
        0, 1, 2: warmup = '0;
        3, 4:    warmup = DATA_W'($urandom_range(1, 10));
        5:       warmup = DATA_W'($urandom_range(0, 3 * interval + 3));
        6:       warmup = '1;
        default: warmup = $urandom();
      endcase
      configure(warmup, interval);
      send_random_frames($urandom_range(60, 140));
      sent += 100;
    end
  endtask

  // sink holds off long enough for the core to fill and stall its input
  task automatic test_backpressure();
    configure('0, INTERVAL_W'(1));
    sink_hold = 600;
    for (int i = 0; i < 30; i++) send_frame(OP_SUBMIT, random_sample());
    wait_reports_drained();
    configure(DATA_W'(1), INTERVAL_W'(2));
    sink_hold = 400;
    for (int i = 0; i < 30; i++) send_frame(OP_SUBMIT, random_sample());
  endtask

  task automatic test_steady_stream();
    configure(DATA_W'(3), INTERVAL_W'(5));
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    send_random_frames(150);
  endtask

  initial begin : main
    frame_cnt    = '0;
    warmup_cfg   = '0;
    interval_cfg = INTERVAL_DEFAULT;
    clear_accumulators();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_config();
    test_random_sweep();
    test_backpressure();
    test_steady_stream();

    wait_reports_drained();
    if (error_count == 0) begin
      $display("[interval_min_max_average_stats_core] OK");
    end else begin
      $display("[interval_min_max_average_stats_core] ERROR");
    end
    $finish;
  end

endmodule
